FILE: hw/rtl/awm_pkg.sv
// Shared constants for the anagram window matcher: default sizes, request
// opcodes, status codes, slot kinds, table operation codes and result buffer sizes.
// No dependencies.
package awm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int OPCODE_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OPC_CLEAR   = 2'd0;
    localparam logic [OPCODE_W-1:0] OPC_PATTERN = 2'd1;
    localparam logic [OPCODE_W-1:0] OPC_TEXT    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AFTER_TEXT = 2'd2;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADJ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

    localparam int TOP_W = 2;
    localparam logic [TOP_W-1:0] TOP_NONE = 2'd0;
    localparam logic [TOP_W-1:0] TOP_ZERO = 2'd1;
    localparam logic [TOP_W-1:0] TOP_DEC  = 2'd2;
    localparam logic [TOP_W-1:0] TOP_INC  = 2'd3;

    localparam int RES_DEPTH = 4;
    localparam int RES_PW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);
    localparam int RES_W     = 2 + STATUS_W;

endpackage

FILE: hw/rtl/anagram_window_matcher.sv
// Top level of the anagram window matcher: request decode, table sequencer,
// read-modify-write stage and result buffer. Uses awm_pkg and awm_ram.
//
// The s_ channel takes one request per handshake: clear, pattern byte or text
// byte. The m_ channel returns exactly one result per request, in order:
// window_match, the sticky found flag and a status code.
// The difference table lives in a RAM with a registered read. Each request
// issues table slots, one per cycle: a text byte with a full window issues two
// (retire the oldest byte, add the new one), other requests issue one, and a
// clear issues 2^SYMBOL_BITS slots that sweep the table to zero.
// Throughput is one request per cycle while fewer than four requests are
// outstanding; after a text byte with a full window or a clear, the next
// request is accepted only as its last slot issues on the single table port.
// A result enters the buffer when the last slot of its request passes the
// read-modify-write stage.
// Up to four results are buffered; when the receiver stalls, s_ready falls once
// four requests are outstanding and nothing is lost.
// After reset the block sweeps all 2^SYMBOL_BITS table entries to zero, holding
// s_ready low until its last slot issues; the window ring needs no clearing.
module anagram_window_matcher #(
    parameter int MAX_PATTERN = awm_pkg::MAX_PATTERN_DEF,
    parameter int SYMBOL_BITS = awm_pkg::SYMBOL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [awm_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [awm_pkg::SYMBOL_W-1:0]  s_symbol,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_window_match,
    output logic                          m_found,
    output logic [awm_pkg::STATUS_W-1:0]  m_status
);

    localparam int SYM_N = 1 << SYMBOL_BITS;
    localparam int LW    = $clog2(MAX_PATTERN + 1);
    localparam int DW    = LW + 1;
    localparam int HW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NZW   = SYMBOL_BITS + 1;

    logic                         s_accept;
    logic [SYMBOL_BITS-1:0]       sym_in;

    logic [LW-1:0]                plen_reg, plen_next;
    logic [LW-1:0]                fill_reg, fill_next;
    logic [HW-1:0]                head_reg, head_next;
    logic [LW-1:0]                head_inc;
    logic                         started_reg, started_next;
    logic                         win_we;
    logic [SYMBOL_BITS-1:0]       win_rdata;

    logic [awm_pkg::KIND_W-1:0]   n_kind;
    logic [awm_pkg::STATUS_W-1:0] n_status;
    logic                         n_retire, n_check, n_force;

    logic                         f_valid_reg, f_valid_next;
    logic [awm_pkg::KIND_W-1:0]   f_kind_reg, f_kind_next;
    logic [SYMBOL_BITS-1:0]       f_sym_reg, f_sym_next;
    logic                         f_retire_reg, f_retire_next;
    logic                         f_phase_reg, f_phase_next;
    logic [SYMBOL_BITS-1:0]       f_cnt_reg, f_cnt_next;
    logic                         f_result_reg, f_result_next;
    logic [awm_pkg::STATUS_W-1:0] f_status_reg, f_status_next;
    logic                         f_check_reg, f_check_next;
    logic                         f_force_reg, f_force_next;

    logic [awm_pkg::TOP_W-1:0]    iss_op;
    logic [SYMBOL_BITS-1:0]       iss_addr;
    logic                         iss_last;
    logic                         iss_phase;
    logic [SYMBOL_BITS-1:0]       iss_cnt;
    logic                         f_free;

    logic                         w_valid_reg;
    logic [awm_pkg::TOP_W-1:0]    w_op_reg;
    logic [SYMBOL_BITS-1:0]       w_addr_reg;
    logic                         w_last_reg;
    logic                         w_result_reg;
    logic [awm_pkg::STATUS_W-1:0] w_status_reg;
    logic                         w_check_reg;
    logic                         w_force_reg;
    logic                         w_clear_reg;

    logic [DW-1:0]                tbl_rdata;
    logic signed [DW-1:0]         old_val, new_val;
    logic                         tbl_we;
    logic                         fw_valid_reg;
    logic [SYMBOL_BITS-1:0]       fw_addr_reg;
    logic signed [DW-1:0]         fw_data_reg;
    logic [NZW-1:0]               nz_reg, nz_next;
    logic                         found_reg, found_next;
    logic                         match;
    logic                         push;

    logic [awm_pkg::RES_W-1:0]    res_mem_reg [awm_pkg::RES_DEPTH];
    logic [awm_pkg::RES_PW-1:0]   res_wr_reg, res_rd_reg;
    logic [awm_pkg::RES_CW-1:0]   res_cnt_reg, res_cnt_next;
    logic [awm_pkg::RES_CW-1:0]   pend_reg, pend_next;
    logic                         pop;
    logic [awm_pkg::RES_W-1:0]    res_head;

    assign sym_in   = SYMBOL_BITS'(s_symbol);
    assign s_accept = s_valid && s_ready;
    assign head_inc = LW'(head_reg) + LW'(1);

    // Request decode and window bookkeeping at acceptance.
    always_comb begin
        plen_next    = plen_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        started_next = started_reg;
        win_we       = 1'b0;
        n_kind       = awm_pkg::KIND_NOP;
        n_status     = awm_pkg::ST_OK;
        n_retire     = 1'b0;
        n_check      = 1'b0;
        n_force      = 1'b0;
        if (s_accept) begin
            unique case (s_opcode)
                awm_pkg::OPC_CLEAR: begin
                    n_kind       = awm_pkg::KIND_CLEAR;
                    plen_next    = '0;
                    fill_next    = '0;
                    head_next    = '0;
                    started_next = 1'b0;
                end
                awm_pkg::OPC_PATTERN: begin
                    if (started_reg) begin
                        n_status = awm_pkg::ST_AFTER_TEXT;
                    end else if (plen_reg >= LW'(MAX_PATTERN)) begin
                        n_status = awm_pkg::ST_TOO_LONG;
                    end else begin
                        n_kind    = awm_pkg::KIND_ADJ;
                        plen_next = plen_reg + LW'(1);
                    end
                end
                awm_pkg::OPC_TEXT: begin
                    started_next = 1'b1;
                    if (plen_reg == '0) begin
                        n_force = 1'b1;
                    end else begin
                        n_kind    = awm_pkg::KIND_TEXT;
                        n_retire  = (fill_reg >= plen_reg);
                        win_we    = 1'b1;
                        head_next = (head_inc >= plen_reg) ? '0 : head_inc[HW-1:0];
                        fill_next = (fill_reg < plen_reg) ? fill_reg + LW'(1) : fill_reg;
                        n_check   = (fill_next == plen_reg);
                    end
                end
                default: begin
                    n_kind = awm_pkg::KIND_NOP;
                end
            endcase
        end
    end

    awm_ram #(
        .WIDTH (SYMBOL_BITS),
        .DEPTH (MAX_PATTERN)
    ) u_window_ram (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (head_reg),
        .wdata (sym_in),
        .raddr (head_reg),
        .rdata (win_rdata)
    );

    // Slot issue: one table operation per cycle from the front request.
    always_comb begin
        iss_op    = awm_pkg::TOP_NONE;
        iss_addr  = f_sym_reg;
        iss_last  = 1'b1;
        iss_phase = f_phase_reg;
        iss_cnt   = f_cnt_reg;
        unique case (f_kind_reg)
            awm_pkg::KIND_CLEAR: begin
                iss_op   = awm_pkg::TOP_ZERO;
                iss_addr = f_cnt_reg;
                iss_last = (f_cnt_reg == '1);
                iss_cnt  = f_cnt_reg + SYMBOL_BITS'(1);
            end
            awm_pkg::KIND_ADJ: begin
                iss_op = awm_pkg::TOP_DEC;
            end
            awm_pkg::KIND_TEXT: begin
                if (f_retire_reg && !f_phase_reg) begin
                    iss_op    = awm_pkg::TOP_DEC;
                    iss_addr  = win_rdata;
                    iss_last  = 1'b0;
                    iss_phase = 1'b1;
                end else begin
                    iss_op = awm_pkg::TOP_INC;
                end
            end
            awm_pkg::KIND_NOP: begin
                iss_op = awm_pkg::TOP_NONE;
            end
            default: begin
                iss_op = awm_pkg::TOP_NONE;
            end
        endcase
    end

    assign f_free  = !f_valid_reg || iss_last;
    assign s_ready = f_free && (pend_reg < awm_pkg::RES_CW'(awm_pkg::RES_DEPTH));

    always_comb begin
        f_valid_next  = f_valid_reg;
        f_kind_next   = f_kind_reg;
        f_sym_next    = f_sym_reg;
        f_retire_next = f_retire_reg;
        f_phase_next  = iss_phase;
        f_cnt_next    = iss_cnt;
        f_result_next = f_result_reg;
        f_status_next = f_status_reg;
        f_check_next  = f_check_reg;
        f_force_next  = f_force_reg;
        if (s_accept) begin
            f_valid_next  = 1'b1;
            f_kind_next   = n_kind;
            f_sym_next    = sym_in;
            f_retire_next = n_retire;
            f_phase_next  = 1'b0;
            f_cnt_next    = '0;
            f_result_next = 1'b1;
            f_status_next = n_status;
            f_check_next  = n_check;
            f_force_next  = n_force;
        end else if (f_valid_reg && iss_last) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg  <= 1'b1;
            f_kind_reg   <= awm_pkg::KIND_CLEAR;
            f_cnt_reg    <= '0;
            f_phase_reg  <= 1'b0;
            f_result_reg <= 1'b0;
            plen_reg     <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            started_reg  <= 1'b0;
        end else begin
            f_valid_reg  <= f_valid_next;
            f_kind_reg   <= f_kind_next;
            f_cnt_reg    <= f_cnt_next;
            f_phase_reg  <= f_phase_next;
            f_result_reg <= f_result_next;
            plen_reg     <= plen_next;
            fill_reg     <= fill_next;
            head_reg     <= head_next;
            started_reg  <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        f_sym_reg    <= f_sym_next;
        f_retire_reg <= f_retire_next;
        f_status_reg <= f_status_next;
        f_check_reg  <= f_check_next;
        f_force_reg  <= f_force_next;
    end

    always_ff @(posedge aclk) begin
        w_op_reg     <= iss_op;
        w_addr_reg   <= iss_addr;
        w_last_reg   <= iss_last;
        w_result_reg <= f_result_reg;
        w_status_reg <= f_status_reg;
        w_check_reg  <= f_check_reg;
        w_force_reg  <= f_force_reg;
        w_clear_reg  <= (f_kind_reg == awm_pkg::KIND_CLEAR);
    end

    awm_ram #(
        .WIDTH (DW),
        .DEPTH (SYM_N)
    ) u_table_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (w_addr_reg),
        .wdata ($unsigned(new_val)),
        .raddr (iss_addr),
        .rdata (tbl_rdata)
    );

    // Read-modify-write stage; the previous write is forwarded because the
    // table read for this slot was taken at the same edge as that write.
    always_comb begin
        old_val = (fw_valid_reg && (fw_addr_reg == w_addr_reg)) ?
                  fw_data_reg : $signed(tbl_rdata);
        new_val = old_val;
        nz_next = nz_reg;
        unique case (w_op_reg)
            awm_pkg::TOP_NONE: new_val = old_val;
            awm_pkg::TOP_ZERO: new_val = '0;
            awm_pkg::TOP_DEC:  new_val = old_val - DW'(1);
            awm_pkg::TOP_INC:  new_val = old_val + DW'(1);
            default:           new_val = old_val;
        endcase
        if (w_valid_reg) begin
            if (w_op_reg == awm_pkg::TOP_ZERO) begin
                nz_next = '0;
            end else if (w_op_reg == awm_pkg::TOP_DEC || w_op_reg == awm_pkg::TOP_INC) begin
                if (old_val == '0) begin
                    nz_next = nz_reg + NZW'(1);
                end else if (new_val == '0) begin
                    nz_next = nz_reg - NZW'(1);
                end
            end
        end
    end

    assign tbl_we = w_valid_reg && (w_op_reg != awm_pkg::TOP_NONE);
    assign match  = w_valid_reg && w_last_reg &&
                    (w_force_reg || (w_check_reg && (nz_next == '0)));
    assign push   = w_valid_reg && w_last_reg && w_result_reg;

    always_comb begin
        found_next = found_reg;
        if (w_valid_reg && w_last_reg && w_clear_reg) begin
            found_next = 1'b0;
        end else if (match) begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg  <= 1'b0;
            fw_valid_reg <= 1'b0;
            nz_reg       <= '0;
            found_reg    <= 1'b0;
        end else begin
            w_valid_reg  <= f_valid_reg;
            fw_valid_reg <= tbl_we;
            nz_reg       <= nz_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        fw_addr_reg <= w_addr_reg;
        fw_data_reg <= new_val;
    end

    // Result buffer; pend_reg counts requests accepted and not yet delivered.
    assign pop      = m_valid && m_ready;
    assign m_valid  = (res_cnt_reg != '0);
    assign res_head = res_mem_reg[res_rd_reg];

    assign m_window_match = res_head[awm_pkg::RES_W-1];
    assign m_found        = res_head[awm_pkg::RES_W-2];
    assign m_status       = res_head[awm_pkg::STATUS_W-1:0];

    always_comb begin
        res_cnt_next = res_cnt_reg;
        pend_next    = pend_reg;
        if (push && !pop) begin
            res_cnt_next = res_cnt_reg + awm_pkg::RES_CW'(1);
        end else if (!push && pop) begin
            res_cnt_next = res_cnt_reg - awm_pkg::RES_CW'(1);
        end
        if (s_accept && !pop) begin
            pend_next = pend_reg + awm_pkg::RES_CW'(1);
        end else if (!s_accept && pop) begin
            pend_next = pend_reg - awm_pkg::RES_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_wr_reg  <= '0;
            res_rd_reg  <= '0;
            res_cnt_reg <= '0;
            pend_reg    <= '0;
        end else begin
            if (push) begin
                res_wr_reg <= res_wr_reg + awm_pkg::RES_PW'(1);
            end
            if (pop) begin
                res_rd_reg <= res_rd_reg + awm_pkg::RES_PW'(1);
            end
            res_cnt_reg <= res_cnt_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            res_mem_reg[res_wr_reg] <= {match, found_next, w_status_reg};
        end
    end

endmodule

FILE: hw/rtl/awm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// A read of the address being written returns the old contents. No dependencies.
module awm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: test/tb.sv
// Testbench for anagram_window_matcher: drives clear, pattern, text and unused
// requests and checks each result against a typed directed-table value or a
// predictor of the difference-table search. Depends on awm_pkg and the DUT RTL.
`timescale 1ns / 1ps

module tb;

    localparam logic [awm_pkg::OPCODE_W-1:0] OPC_UNUSED = 2'd3;
    localparam int SYM_COUNT = 1 << awm_pkg::SYMBOL_BITS_DEF;
    localparam int MAX_PAT = awm_pkg::MAX_PATTERN_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REQUEST_TARGET = 900;
    localparam int CALM_START = 760;

    typedef struct packed {
        logic                         window_match;
        logic                         found;
        logic [awm_pkg::STATUS_W-1:0] status;
    } window_result_t;

    typedef struct packed {
        logic [awm_pkg::OPCODE_W-1:0] op;
        logic [awm_pkg::SYMBOL_W-1:0] sym;
        logic [7:0]                   reps;
        logic                         typed;
        window_result_t               res;
    } directed_row_t;

    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [awm_pkg::OPCODE_W-1:0] s_opcode;
    logic [awm_pkg::SYMBOL_W-1:0] s_symbol;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_window_match;
    logic                         m_found;
    logic [awm_pkg::STATUS_W-1:0] m_status;

    logic signed [7:0] diff_count [SYM_COUNT];
    logic [8:0]        nonzero_syms;
    logic [6:0]        pattern_len;
    logic [6:0]        window_fill;
    logic [7:0]        window_ring [MAX_PAT];
    logic [5:0]        ring_head;
    logic              text_started;
    logic              found_flag;

    window_result_t pending_results [$];
    int  mismatch_count = 0;
    int  requests_sent = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;
    bit  sender_idles = 1'b1;
    bit  recv_idles = 1'b1;
    bit  hold_request = 1'b0;

    directed_row_t directed_rows [21] = '{
        '{awm_pkg::OPC_CLEAR,   8'h00, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_TEXT,    8'h00, 8'd1,  1'b1, '{1'b1, 1'b1, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_TEXT,    8'hFF, 8'd1,  1'b1, '{1'b1, 1'b1, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_PATTERN, 8'hFF, 8'd1,  1'b1,
          '{1'b0, 1'b1, awm_pkg::ST_AFTER_TEXT}},
        '{OPC_UNUSED,           8'hAA, 8'd1,  1'b1, '{1'b0, 1'b1, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_CLEAR,   8'hFF, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{OPC_UNUSED,           8'h55, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_PATTERN, 8'h00, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_PATTERN, 8'hFF, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_TEXT,    8'hFF, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_TEXT,    8'h00, 8'd1,  1'b0, '0},
        '{awm_pkg::OPC_TEXT,    8'h00, 8'd1,  1'b0, '0},
        '{awm_pkg::OPC_TEXT,    8'hFF, 8'd1,  1'b0, '0},
        '{awm_pkg::OPC_CLEAR,   8'h00, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_PATTERN, 8'h5A, 8'd64, 1'b0, '0},
        '{awm_pkg::OPC_PATTERN, 8'hA5, 8'd1,  1'b1,
          '{1'b0, 1'b0, awm_pkg::ST_TOO_LONG}},
        '{awm_pkg::OPC_TEXT,    8'h5A, 8'd63, 1'b0, '0},
        '{awm_pkg::OPC_TEXT,    8'h5A, 8'd1,  1'b1, '{1'b1, 1'b1, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_TEXT,    8'hA5, 8'd1,  1'b1, '{1'b0, 1'b1, awm_pkg::ST_OK}},
        '{awm_pkg::OPC_PATTERN, 8'h00, 8'd1,  1'b1,
          '{1'b0, 1'b1, awm_pkg::ST_AFTER_TEXT}},
        '{awm_pkg::OPC_CLEAR,   8'h00, 8'd1,  1'b1, '{1'b0, 1'b0, awm_pkg::ST_OK}}
    };

    anagram_window_matcher i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_window_match (m_window_match),
        .m_found        (m_found),
        .m_status       (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void clear_search_state();
        for (int i = 0; i < SYM_COUNT; i++) begin
            diff_count[i] = '0;
        end
        nonzero_syms = '0;
        pattern_len  = '0;
        window_fill  = '0;
        ring_head    = '0;
        text_started = 1'b0;
        found_flag   = 1'b0;
    endfunction

    function automatic void bump_count(logic [7:0] sym, int delta);
        logic signed [7:0] old_v;
        logic signed [7:0] new_v;
        old_v = diff_count[sym];
        new_v = 8'(old_v + delta);
        diff_count[sym] = new_v;
        if (old_v == 0 && new_v != 0) begin
            nonzero_syms++;
        end else if (old_v != 0 && new_v == 0) begin
            nonzero_syms--;
        end
    endfunction

    function automatic window_result_t predict_window_result(logic [1:0] op, logic [7:0] sym);
        window_result_t res;
        int slot;
        res = '0;
        case (op)
            awm_pkg::OPC_CLEAR: begin
                clear_search_state();
            end
            awm_pkg::OPC_PATTERN: begin
                if (text_started) begin
                    res.status = awm_pkg::ST_AFTER_TEXT;
                end else if (pattern_len >= MAX_PAT) begin
                    res.status = awm_pkg::ST_TOO_LONG;
                end else begin
                    bump_count(sym, -1);
                    pattern_len++;
                end
            end
            awm_pkg::OPC_TEXT: begin
                text_started = 1'b1;
                if (pattern_len == 0) begin
                    res.window_match = 1'b1;
                end else begin
                    slot = ring_head;
                    if (window_fill >= pattern_len) begin
                        bump_count(window_ring[slot], -1);
                    end
                    window_ring[slot] = sym;
                    bump_count(sym, 1);
                    slot++;
                    ring_head = (slot >= pattern_len) ? 6'd0 : slot[5:0];
                    if (window_fill < pattern_len) begin
                        window_fill++;
                    end
                    if (window_fill == pattern_len && nonzero_syms == 0) begin
                        res.window_match = 1'b1;
                    end
                end
                if (res.window_match) begin
                    found_flag = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.found = found_flag;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                                input logic typed, input window_result_t typed_res);
        window_result_t predicted;
        s_opcode = op;
        s_symbol = sym;
        s_valid  = 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = predict_window_result(op, sym);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        if (op != OPC_UNUSED) begin
            requests_sent++;
        end
        @(negedge aclk);
        if (sender_idles && !calm && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!calm && recv_idles && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
            if ($urandom_range(0, 99) == 0) begin
                recv_idles = !recv_idles;
            end
        end
    end

    always @(posedge aclk) begin
        window_result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: window_match %0d found %0d status %0d",
                       m_window_match, m_found, m_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_window_match !== want.window_match) begin
                    $error("window_match: expected %0d, actual %0d",
                           want.window_match, m_window_match);
                    mismatch_count++;
                end
                if (m_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, m_found);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] pattern_bytes [$];
        logic [7:0] shuffled [$];
        logic [7:0] alphabet [4];
        logic [7:0] swap_byte;
        int  nsyms;
        int  plen;
        int  tlen;
        int  sent_text;
        int  pick;
        int  k;
        bit  hold_done;
        bit  drain_done;

        hold_done  = 1'b0;
        drain_done = 1'b0;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_opcode = awm_pkg::OPC_CLEAR;
        s_symbol = '0;
        clear_search_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[r]) begin
            for (int n = 0; n < directed_rows[r].reps; n++) begin
                send_request(directed_rows[r].op, directed_rows[r].sym,
                             directed_rows[r].typed, directed_rows[r].res);
            end
        end

        while (requests_sent < REQUEST_TARGET) begin
            if (requests_sent >= CALM_START) begin
                calm = 1'b1;
            end
            if (!hold_done && requests_sent >= 250) begin
                hold_request = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && requests_sent >= 450) begin
                s_valid = 1'b0;
                while (pending_results.size() != 0) @(negedge aclk);
                drain_done = 1'b1;
            end
            sender_idles = ($urandom_range(0, 2) != 0);

            if ($urandom_range(0, 3) != 0) begin
                send_request(awm_pkg::OPC_CLEAR, 8'($urandom), 1'b0, '0);
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    plen = 0;
                end else if (pick == 1) begin
                    plen = $urandom_range(7, MAX_PAT);
                end else if (pick == 2) begin
                    plen = $urandom_range(MAX_PAT + 1, MAX_PAT + 3);
                end else begin
                    plen = $urandom_range(1, 6);
                end
                nsyms = $urandom_range(1, 4);
                foreach (alphabet[a]) begin
                    alphabet[a] = 8'($urandom);
                end
                pattern_bytes.delete();
                for (int i = 0; i < plen; i++) begin
                    swap_byte = alphabet[$urandom_range(0, nsyms - 1)];
                    if (i < MAX_PAT) begin
                        pattern_bytes.insert(pattern_bytes.size(), swap_byte);
                    end
                    send_request(awm_pkg::OPC_PATTERN, swap_byte, 1'b0, '0);
                end
                tlen = $urandom_range(1, 3 * pattern_bytes.size() + 4);
                sent_text = 0;
                while (sent_text < tlen) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3 && pattern_bytes.size() > 0) begin
                        shuffled = pattern_bytes;
                        for (int j = shuffled.size() - 1; j > 0; j--) begin
                            k = $urandom_range(0, j);
                            swap_byte = shuffled[j];
                            shuffled[j] = shuffled[k];
                            shuffled[k] = swap_byte;
                        end
                        foreach (shuffled[j]) begin
                            send_request(awm_pkg::OPC_TEXT, shuffled[j], 1'b0, '0);
                        end
                        sent_text += shuffled.size();
                    end else if (pick == 9) begin
                        send_request(($urandom_range(0, 1) != 0) ?
                                     awm_pkg::OPC_PATTERN : OPC_UNUSED,
                                     8'($urandom), 1'b0, '0);
                    end else if (pick == 8) begin
                        send_request(awm_pkg::OPC_TEXT, 8'($urandom), 1'b0, '0);
                        sent_text++;
                    end else begin
                        send_request(awm_pkg::OPC_TEXT,
                                     alphabet[$urandom_range(0, nsyms - 1)], 1'b0, '0);
                        sent_text++;
                    end
                end
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    send_request(2'($urandom_range(0, 3)), 8'($urandom), 1'b0, '0);
                end
            end
        end

        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/awm_pkg.sv
hw/rtl/awm_ram.sv
hw/rtl/anagram_window_matcher.sv
test/tb.sv
